// ===== rtl/core/ttdt_pkg.sv =====
// Package for the timed task dispatch table.
// Holds the request and response word types, codes and shared constants.
// Used by ttdt_front, ttdt_back and timed_task_dispatch_table.
package ttdt_pkg;

   // Default table depth.
   localparam int MAX_ENTRIES_DEF = 8;
   // Most due tasks reported by one dispatch pass.
   localparam int RESULT_LIMIT = 8;
   localparam int RESULT_CW = 4;

   typedef enum logic [1:0] {
      REQ_SET      = 2'd0,
      REQ_DELETE   = 2'd1,
      REQ_TICK     = 2'd2,
      REQ_DISPATCH = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_ADDED     = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_FULL      = 3'd2,
      ST_DELETED   = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_TICK      = 3'd5,
      ST_DUE       = 3'd6,
      ST_NONE_DUE  = 3'd7
   } status_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  task_id;
      logic [15:0] delay_ticks;
      logic [15:0] period_ticks;
   } req_word_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] due_id;
      logic       removed;
      logic       last;
   } rsp_word_type;

   // One table entry.
   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] delay;
      logic [15:0] period;
      logic        run;
   } entry_type;

   // Queue output toward the back end.
   typedef struct packed {
      logic         valid;
      req_word_type word;
   } queue_head_type;

   typedef enum logic [3:0] {
      SQ_IDLE,
      SQ_FIND_RD,
      SQ_FIND_CHK,
      SQ_MOVE,
      SQ_AGE_RD,
      SQ_AGE_WR,
      SQ_SCAN_RD,
      SQ_SCAN_CHK
   } seq_state_type;

endpackage

// ===== rtl/core/ttdt_front.sv =====
// Front end of the timed task dispatch table: a two-word request queue.
// Depends on ttdt_pkg for the request word and queue head types.
module ttdt_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ttdt_pkg::req_word_type req,
   input  logic                  pop,
   output ttdt_pkg::queue_head_type head
);

   ttdt_pkg::req_word_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       do_pop;

   // Accept while a slot is free; pop only when a word is held.
   assign busy   = (count_ff == 2'd2);
   assign push   = start && !busy;
   assign do_pop = pop && (count_ff != 2'd0);
   assign head.valid = (count_ff != 2'd0);
   assign head.word  = slot_ff[rd_ptr_ff];

   // Pointer and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, do_pop};
      end
   end

   // Payload storage.
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= req;
   end

endmodule

// ===== rtl/core/ttdt_back.sv =====
// Back end of the timed task dispatch table: the table memory and the sequencer
// that walks it for set, delete, tick and dispatch words.
// Depends on ttdt_pkg for word, entry, status and state types.
module ttdt_back #(
   parameter int MAX_ENTRIES = ttdt_pkg::MAX_ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ttdt_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   output ttdt_pkg::rsp_word_type   rsp
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);
   localparam logic [ttdt_pkg::RESULT_CW-1:0] LIMIT = ttdt_pkg::RESULT_CW'(ttdt_pkg::RESULT_LIMIT);

   ttdt_pkg::entry_type mem [MAX_ENTRIES];
   ttdt_pkg::entry_type rd_data_ff;

   ttdt_pkg::seq_state_type state_ff, state_in;
   ttdt_pkg::req_word_type  cmd_ff, cmd_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [AW-1:0] dst_ff, dst_in;
   logic          tick_ff, tick_in;
   logic [ttdt_pkg::RESULT_CW-1:0] n_ff, n_in;
   logic          pend_ff, pend_in;
   logic [7:0]    pend_id_ff, pend_id_in;
   logic          pend_rem_ff, pend_rem_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ttdt_pkg::rsp_word_type rsp_ff, rsp_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   ttdt_pkg::entry_type wr_data;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] tail;

   assign tail      = used_ff - CW'(1);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttdt_pkg::SQ_IDLE;
         used_ff      <= '0;
         tick_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         tick_ff      <= tick_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      dst_ff      <= dst_in;
      n_ff        <= n_in;
      pend_id_ff  <= pend_id_in;
      pend_rem_ff <= pend_rem_in;
      rsp_ff      <= rsp_in;
   end

   // Next state, memory control and result words.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      used_in      = used_ff;
      idx_in       = idx_ff;
      dst_in       = dst_ff;
      tick_in      = tick_ff;
      n_in         = n_ff;
      pend_in      = pend_ff;
      pend_id_in   = pend_id_ff;
      pend_rem_in  = pend_rem_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = rd_data_ff;
      rd_addr      = idx_ff[AW-1:0];

      unique case (state_ff)
         ttdt_pkg::SQ_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               cmd_in  = head.word;
               idx_in  = '0;
               n_in    = '0;
               pend_in = 1'b0;
               unique case (head.word.req_type)
                  ttdt_pkg::REQ_SET: begin
                     // A set with id zero is dropped silently.
                     if (head.word.task_id != 8'd0) state_in = ttdt_pkg::SQ_FIND_RD;
                  end
                  ttdt_pkg::REQ_DELETE: state_in = ttdt_pkg::SQ_FIND_RD;
                  ttdt_pkg::REQ_TICK: begin
                     tick_in         = 1'b1;
                     rsp_valid_in    = 1'b1;
                     rsp_in.status   = ttdt_pkg::ST_TICK;
                     rsp_in.last     = 1'b1;
                  end
                  default: begin
                     state_in = tick_ff ? ttdt_pkg::SQ_AGE_RD : ttdt_pkg::SQ_SCAN_RD;
                  end
               endcase
            end
         end

         ttdt_pkg::SQ_FIND_RD: begin
            if (idx_ff >= used_ff) begin
               // Id not in the table.
               state_in     = ttdt_pkg::SQ_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in.last  = 1'b1;
               if (cmd_ff.req_type == ttdt_pkg::REQ_DELETE) begin
                  rsp_in.status = ttdt_pkg::ST_NOT_FOUND;
               end else if (used_ff < FULL_COUNT) begin
                  wr_en         = 1'b1;
                  wr_addr       = used_ff[AW-1:0];
                  wr_data       = '{id: cmd_ff.task_id, delay: cmd_ff.delay_ticks,
                                    period: cmd_ff.period_ticks, run: 1'b0};
                  used_in       = used_ff + CW'(1);
                  rsp_in.status = ttdt_pkg::ST_ADDED;
               end else begin
                  rsp_in.status = ttdt_pkg::ST_FULL;
               end
            end else begin
               state_in = ttdt_pkg::SQ_FIND_CHK;
            end
         end

         ttdt_pkg::SQ_FIND_CHK: begin
            if (rd_data_ff.id == cmd_ff.task_id) begin
               if (cmd_ff.req_type == ttdt_pkg::REQ_SET) begin
                  wr_en         = 1'b1;
                  wr_data       = '{id: rd_data_ff.id, delay: cmd_ff.delay_ticks,
                                    period: cmd_ff.period_ticks, run: 1'b0};
                  state_in      = ttdt_pkg::SQ_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ttdt_pkg::ST_UPDATED;
                  rsp_in.last   = 1'b1;
               end else if (idx_ff == tail) begin
                  used_in       = tail;
                  state_in      = ttdt_pkg::SQ_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ttdt_pkg::ST_DELETED;
                  rsp_in.last   = 1'b1;
               end else begin
                  rd_addr  = tail[AW-1:0];
                  dst_in   = idx_ff[AW-1:0];
                  state_in = ttdt_pkg::SQ_MOVE;
               end
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ttdt_pkg::SQ_FIND_RD;
            end
         end

         ttdt_pkg::SQ_MOVE: begin
            // The last entry fills the freed slot.
            wr_en   = 1'b1;
            wr_addr = dst_ff;
            used_in = tail;
            if (cmd_ff.req_type == ttdt_pkg::REQ_DELETE) begin
               state_in      = ttdt_pkg::SQ_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_in.status = ttdt_pkg::ST_DELETED;
               rsp_in.last   = 1'b1;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ttdt_pkg::SQ_SCAN_RD;
            end
         end

         ttdt_pkg::SQ_AGE_RD: begin
            if (idx_ff >= used_ff) begin
               tick_in  = 1'b0;
               idx_in   = '0;
               state_in = ttdt_pkg::SQ_SCAN_RD;
            end else begin
               state_in = ttdt_pkg::SQ_AGE_WR;
            end
         end

         ttdt_pkg::SQ_AGE_WR: begin
            // Count the delay down, or mark the entry to run.
            wr_en = 1'b1;
            if (rd_data_ff.delay == 16'd0) wr_data.run = 1'b1;
            else wr_data.delay = rd_data_ff.delay - 16'd1;
            idx_in   = idx_ff + CW'(1);
            state_in = ttdt_pkg::SQ_AGE_RD;
         end

         ttdt_pkg::SQ_SCAN_RD: begin
            if (idx_ff >= used_ff || n_ff == LIMIT) begin
               // Flush the held result as the final word, or send a none-due word if none is held.
               state_in     = ttdt_pkg::SQ_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in.last  = 1'b1;
               if (pend_ff) begin
                  rsp_in.status  = ttdt_pkg::ST_DUE;
                  rsp_in.due_id  = pend_id_ff;
                  rsp_in.removed = pend_rem_ff;
               end else begin
                  rsp_in.status = ttdt_pkg::ST_NONE_DUE;
               end
               pend_in = 1'b0;
            end else begin
               state_in = ttdt_pkg::SQ_SCAN_CHK;
            end
         end

         ttdt_pkg::SQ_SCAN_CHK: begin
            state_in = ttdt_pkg::SQ_SCAN_RD;
            idx_in   = idx_ff + CW'(1);
            if (rd_data_ff.run) begin
               // A result is held one step so the final one can carry last.
               if (pend_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_in.status  = ttdt_pkg::ST_DUE;
                  rsp_in.due_id  = pend_id_ff;
                  rsp_in.removed = pend_rem_ff;
               end
               pend_in     = 1'b1;
               pend_id_in  = rd_data_ff.id;
               pend_rem_in = (rd_data_ff.period == 16'd0);
               n_in        = n_ff + ttdt_pkg::RESULT_CW'(1);
               if (rd_data_ff.period == 16'd0) begin
                  if (idx_ff == tail) begin
                     used_in = tail;
                  end else begin
                     rd_addr  = tail[AW-1:0];
                     dst_in   = idx_ff[AW-1:0];
                     idx_in   = idx_ff;
                     state_in = ttdt_pkg::SQ_MOVE;
                  end
               end else begin
                  wr_en       = 1'b1;
                  wr_data.run = 1'b0;
                  if (rd_data_ff.delay == 16'd0) wr_data.delay = rd_data_ff.period - 16'd1;
               end
            end
         end

         default: state_in = ttdt_pkg::SQ_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/timed_task_dispatch_table.sv =====
// Top level of the timed task dispatch table.
// Instantiates ttdt_front and ttdt_back; depends on ttdt_pkg.
//
// A request word is taken when start is high and busy is low; two words can
// wait in the queue while the table sequencer works. Each result word appears
// on rsp for one cycle with rsp_valid high and cannot be held off, and the
// final word of a request has last set. The sequencer reads table entries one
// at a time through a single registered memory port and takes the next
// request from the queue only in its idle state. Set and delete search the
// table entry by entry; dispatch first ages every entry when a tick is
// pending, then scans for due entries, closing the gap left by each removed
// one-shot entry with the last entry. A set with id zero gives no result word.
module timed_task_dispatch_table #(
   parameter int MAX_ENTRIES = ttdt_pkg::MAX_ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ttdt_pkg::req_word_type req,
   output logic                   rsp_valid,
   output ttdt_pkg::rsp_word_type rsp
);

   ttdt_pkg::queue_head_type head;
   logic pop;

   // Request queue.
   ttdt_front u_front (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .req   (req),
      .pop   (pop),
      .head  (head)
   );

   // Table and sequencer.
   ttdt_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   // Only due words carry an id; stored ids are never zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != ttdt_pkg::ST_DUE |-> rsp.due_id == 8'd0 && !rsp.removed)
      else $error("non-due result carries an id");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == ttdt_pkg::ST_DUE |-> rsp.due_id != 8'd0)
      else $error("due result with id zero");

   // Tick, set and delete words are always single and final.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != ttdt_pkg::ST_DUE |-> rsp.last)
      else $error("single result word without last");

endmodule

// ===== dv/ttdt_scoreboard.sv =====
// Scoreboard for the timed task dispatch table testbench.
// Holds a behavioral model of the task table and a queue of expected words.
// Depends on ttdt_pkg.
`timescale 1ns / 100ps

class ttdt_scoreboard;
   localparam int DEPTH = ttdt_pkg::MAX_ENTRIES_DEF;

   ttdt_pkg::entry_type table_q[DEPTH];
   int unsigned used;
   bit tick_seen;
   ttdt_pkg::rsp_word_type pending_words[$];
   int unsigned error_count;
   int unsigned words_checked;
   int unsigned due_words;

   function void clear();
      used = 0;
      tick_seen = 0;
      pending_words.delete();
      error_count = 0;
      words_checked = 0;
      due_words = 0;
   endfunction

   function void push_word(ttdt_pkg::status_type st, logic [7:0] id, logic rem);
      ttdt_pkg::rsp_word_type w;
      w.status = st;
      w.due_id = id;
      w.removed = rem;
      w.last = 1'b0;
      pending_words.push_back(w);
   endfunction

   function int find_task(logic [7:0] id);
      for (int s = 0; s < int'(used); s++)
         if (table_q[s].id == id) return s;
      return -1;
   endfunction

   function void drop_slot(int s);
      if (s != int'(used) - 1) table_q[s] = table_q[used - 1];
      used--;
   endfunction

   // Update the table for one accepted request word and queue its results.
   function void note_request(ttdt_pkg::req_word_type r);
      int s;
      int n;
      int first;
      first = pending_words.size();
      n = 0;
      case (ttdt_pkg::req_code_type'(r.req_type))
         ttdt_pkg::REQ_SET: begin
            if (r.task_id == 8'd0) return;
            s = find_task(r.task_id);
            if (s >= 0) begin
               table_q[s].delay = r.delay_ticks;
               table_q[s].period = r.period_ticks;
               table_q[s].run = 1'b0;
               push_word(ttdt_pkg::ST_UPDATED, 8'd0, 1'b0);
            end else if (used < DEPTH) begin
               table_q[used] = '{r.task_id, r.delay_ticks, r.period_ticks, 1'b0};
               used++;
               push_word(ttdt_pkg::ST_ADDED, 8'd0, 1'b0);
            end else begin
               push_word(ttdt_pkg::ST_FULL, 8'd0, 1'b0);
            end
         end
         ttdt_pkg::REQ_DELETE: begin
            s = find_task(r.task_id);
            if (s >= 0) begin
               drop_slot(s);
               push_word(ttdt_pkg::ST_DELETED, 8'd0, 1'b0);
            end else begin
               push_word(ttdt_pkg::ST_NOT_FOUND, 8'd0, 1'b0);
            end
         end
         ttdt_pkg::REQ_TICK: begin
            tick_seen = 1'b1;
            push_word(ttdt_pkg::ST_TICK, 8'd0, 1'b0);
         end
         default: begin
            // Age the table once for a pending tick, then report due tasks.
            if (tick_seen) begin
               tick_seen = 1'b0;
               for (int i = 0; i < int'(used); i++)
                  if (table_q[i].delay == 16'd0) table_q[i].run = 1'b1;
                  else table_q[i].delay = table_q[i].delay - 16'd1;
            end
            for (int i = 0; i < int'(used) && n < ttdt_pkg::RESULT_LIMIT; i++) begin
               if (!table_q[i].run) continue;
               if (table_q[i].period == 16'd0) begin
                  // One-shot: the entry swapped in is not looked at this pass.
                  push_word(ttdt_pkg::ST_DUE, table_q[i].id, 1'b1);
                  drop_slot(i);
               end else begin
                  push_word(ttdt_pkg::ST_DUE, table_q[i].id, 1'b0);
                  table_q[i].run = 1'b0;
                  if (table_q[i].delay == 16'd0)
                     table_q[i].delay = table_q[i].period - 16'd1;
               end
               n++;
            end
            if (n == 0) push_word(ttdt_pkg::ST_NONE_DUE, 8'd0, 1'b0);
         end
      endcase
      if (pending_words.size() > first)
         pending_words[pending_words.size() - 1].last = 1'b1;
   endfunction

   task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Compare one result word against the oldest expectation.
   task check_word(ttdt_pkg::rsp_word_type got);
      ttdt_pkg::rsp_word_type want;
      words_checked++;
      if (pending_words.size() == 0) begin
         report($sformatf("unexpected word %p", got));
         return;
      end
      want = pending_words.pop_front();
      if (want.status == ttdt_pkg::ST_DUE) due_words++;
      if (got.status !== want.status)
         report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.due_id !== want.due_id)
         report($sformatf("due_id %0d, expected %0d", got.due_id, want.due_id));
      if (got.removed !== want.removed)
         report($sformatf("removed %b, expected %b", got.removed, want.removed));
      if (got.last !== want.last)
         report($sformatf("last %b, expected %b", got.last, want.last));
   endtask
endclass

// ===== dv/testbench.sv =====
// Top of the timed task dispatch table testbench.
// Drives set, delete, tick and dispatch words and checks every result word.
// Depends on ttdt_pkg, ttdt_scoreboard and timed_task_dispatch_table.
`timescale 1ns / 100ps

module testbench;

   localparam int CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   ttdt_pkg::req_word_type req;
   logic rsp_valid;
   ttdt_pkg::rsp_word_type rsp;
   int unsigned cycle_count;
   bit idle_allowed;
   ttdt_scoreboard table_board;

   timed_task_dispatch_table DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req(req), .rsp_valid(rsp_valid), .rsp(rsp)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Check result words and guard against a hang.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) table_board.check_word(rsp);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Present one word and hold it until the block takes it. Start stays high
   // into the next word unless the sender idles first.
   task automatic send_word(ttdt_pkg::req_code_type kind, logic [7:0] id,
                            logic [15:0] dly, logic [15:0] per);
      int gap;
      if (idle_allowed && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req <= '{kind, id, dly, per};
      do @(posedge clock); while (busy);
      table_board.note_request('{kind, id, dly, per});
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (table_board.pending_words.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // Small ids keep updates and deletes hitting entries that exist.
   function automatic logic [7:0] pick_id();
      return ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
   endfunction

   function automatic logic [15:0] pick_ticks();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, 3));
      endcase
   endfunction

   initial begin
      int k;
      table_board = new();
      table_board.clear();
      cycle_count = 0;
      idle_allowed = 1'b0;
      start = 1'b0;
      req = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: ignored id zero, fill, overflow, update, deletes, ticks, dispatch.
      send_word(ttdt_pkg::REQ_SET, 8'd0, 16'd5, 16'd5);
      send_word(ttdt_pkg::REQ_DISPATCH, 8'd0, 16'd0, 16'd0);
      for (k = 1; k <= 8; k++)
         send_word(ttdt_pkg::REQ_SET, 8'(k), (k % 2) ? 16'd0 : 16'd1,
                   (k < 4) ? 16'd0 : 16'd2);
      send_word(ttdt_pkg::REQ_SET, 8'd255, 16'hFFFF, 16'hFFFF);
      send_word(ttdt_pkg::REQ_SET, 8'd8, 16'hFFFF, 16'hFFFF);
      send_word(ttdt_pkg::REQ_DELETE, 8'd0, 16'd0, 16'd0);
      send_word(ttdt_pkg::REQ_DELETE, 8'd200, 16'd0, 16'd0);
      send_word(ttdt_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0);
      send_word(ttdt_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0);
      send_word(ttdt_pkg::REQ_DISPATCH, 8'd0, 16'd0, 16'd0);
      send_word(ttdt_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0);
      send_word(ttdt_pkg::REQ_DISPATCH, 8'd0, 16'd0, 16'd0);
      send_word(ttdt_pkg::REQ_DELETE, 8'd4, 16'd0, 16'd0);
      send_word(ttdt_pkg::REQ_SET, 8'd255, 16'd0, 16'd1);
      send_word(ttdt_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0);
      send_word(ttdt_pkg::REQ_DISPATCH, 8'd0, 16'd0, 16'd0);
      wait_drained();

      // Random: mostly small ids and delays with plenty of ticks and dispatches.
      idle_allowed = 1'b1;
      for (k = 0; k < 180; k++) begin
         if (k == 90) wait_drained();
         if (k == 150) idle_allowed = 1'b0;
         case ($urandom_range(0, 9))
            0, 1, 2: send_word(ttdt_pkg::REQ_SET, pick_id(), pick_ticks(), pick_ticks());
            3: send_word(ttdt_pkg::REQ_DELETE, pick_id(), 16'($urandom), 16'($urandom));
            4, 5, 6: send_word(ttdt_pkg::REQ_TICK, 8'($urandom), 16'($urandom),
                               16'($urandom));
            default: send_word(ttdt_pkg::REQ_DISPATCH, 8'($urandom), 16'($urandom),
                               16'($urandom));
         endcase
      end
      wait_drained();

      $display("Checked %0d result words, %0d of them due-task reports.",
               table_board.words_checked, table_board.due_words);
      if (table_board.error_count == 0 && table_board.pending_words.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
